// ----- hdl/bwtw_pkg.sv -----
// bwtw_pkg: shared types, codes and widths of the bounded window text writer
// no dependencies; used by the top level and its port checker

package bwtw_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned CoordW  = 8;
  localparam int unsigned StrideW = 9;
  localparam int unsigned ColorW  = 4;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 9;
  localparam int unsigned OutDatW = AddrW + CharW + 2 * ColorW;

  // tdata bit positions of the result fields
  localparam int unsigned GlyphLsb = AddrW;
  localparam int unsigned FgLsb    = AddrW + CharW;
  localparam int unsigned BgLsb    = AddrW + CharW + ColorW;

  localparam logic [CharW-1:0] CodeBackspace = 8'd8;
  localparam logic [CharW-1:0] CodeTab       = 8'd9;
  localparam logic [CharW-1:0] CodeNewline   = 8'd10;
  localparam logic [CharW-1:0] CodeSpace     = 8'd32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWinLeft   = 3'd0,
    CfgWinTop    = 3'd1,
    CfgWinRight  = 3'd2,
    CfgWinBottom = 3'd3,
    CfgScrWidth  = 3'd4,
    CfgFgColor   = 3'd5,
    CfgBgColor   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0]  win_left;
    logic [CoordW-1:0]  win_top;
    logic [CoordW-1:0]  win_right;
    logic [CoordW-1:0]  win_bottom;
    logic [StrideW-1:0] scr_width;
    logic [ColorW-1:0]  ink_color;
    logic [ColorW-1:0]  paper_color;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } cursor_t;

  // row step with equality wrap at the bottom
  function automatic logic [CoordW-1:0] next_row(cfg_t cfg, logic [CoordW-1:0] row);
    logic [CoordW-1:0] res;
    if (row == cfg.win_bottom) begin
      res = cfg.win_top;
    end else begin
      res = row + 1'b1;
    end
    return res;
  endfunction

  // cursor step after one cell write
  function automatic cursor_t advance(cfg_t cfg, cursor_t cur);
    cursor_t res;
    if (cur.col == cfg.win_right) begin
      res.col = cfg.win_left;
      res.row = next_row(cfg, cur.row);
    end else begin
      res.col = cur.col + 1'b1;
      res.row = cur.row;
    end
    return res;
  endfunction

endpackage

// ----- hdl/bounded_window_text_writer_unit.sv -----
// bounded_window_text_writer_unit: character to cell-write converter for a text window
// depends on bwtw_pkg
//
//  channel   dir  payload                                   request taken when
//  s_axis    in   tdata[7:0] char_code                      s_axis_tvalid & s_axis_tready
//  m_axis    out  tdata addr/glyph/fg/bg, tlast last_of_run m_axis_tvalid & m_axis_tready
//  cfg       in   cfg_index_i, cfg_data_i                   cfg_valid_i & cfg_ready_o
//
// one char per cycle unless stalled or tab-held; result reg after one 8x9 multiply-add
// a tab holds s_axis_tready low for one output slot while its second space goes out
// newline and backspace produce no result and leave the output slot free
// reset puts the window registers at their defaults and the cursor at (0, 0)
// a stalled m_axis side holds the result register and stops input only when it is full

module bounded_window_text_writer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: char_code[7:0]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bwtw_pkg::CharW-1:0]     s_axis_tdata,
  // tdata: write_address[15:0], glyph[23:16], cell_fg[27:24], cell_bg[31:28]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bwtw_pkg::OutDatW-1:0]   m_axis_tdata,
  // tlast: last_of_run
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bwtw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bwtw_pkg::CfgDatW-1:0]   cfg_data_i
);

  bwtw_pkg::cfg_t    cfg_q;
  bwtw_pkg::cursor_t cur_q, cur_d;
  logic              tab_pend_q, tab_pend_d;
  logic              out_valid_q, out_valid_d;
  logic [bwtw_pkg::OutDatW-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  logic                          adv;
  logic                          in_acc;
  logic                          emit;
  logic [bwtw_pkg::CharW-1:0]    emit_code;
  logic                          emit_last;
  logic [bwtw_pkg::AddrW:0]      prod;
  logic [bwtw_pkg::AddrW-1:0]    addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_left    <= 8'd0;
      cfg_q.win_top     <= 8'd0;
      cfg_q.win_right   <= 8'd79;
      cfg_q.win_bottom  <= 8'd24;
      cfg_q.scr_width   <= 9'd80;
      cfg_q.ink_color   <= 4'd7;
      cfg_q.paper_color <= 4'd0;
    end else if (cfg_valid_i) begin
      case (bwtw_pkg::cfg_idx_e'(cfg_index_i))
        bwtw_pkg::CfgWinLeft:   cfg_q.win_left    <= cfg_data_i[bwtw_pkg::CoordW-1:0];
        bwtw_pkg::CfgWinTop:    cfg_q.win_top     <= cfg_data_i[bwtw_pkg::CoordW-1:0];
        bwtw_pkg::CfgWinRight:  cfg_q.win_right   <= cfg_data_i[bwtw_pkg::CoordW-1:0];
        bwtw_pkg::CfgWinBottom: cfg_q.win_bottom  <= cfg_data_i[bwtw_pkg::CoordW-1:0];
        bwtw_pkg::CfgScrWidth:  cfg_q.scr_width   <= cfg_data_i;
        bwtw_pkg::CfgFgColor:   cfg_q.ink_color   <= cfg_data_i[bwtw_pkg::ColorW-1:0];
        bwtw_pkg::CfgBgColor:   cfg_q.paper_color <= cfg_data_i[bwtw_pkg::ColorW-1:0];
        default: ;
      endcase
    end
  end

  // output slot can take a new result this cycle
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv && !tab_pend_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cur_d      = cur_q;
    tab_pend_d = tab_pend_q;
    emit       = 1'b0;
    emit_code  = bwtw_pkg::CodeSpace;
    emit_last  = 1'b1;
    if (tab_pend_q && adv) begin
      // second space of a tab
      emit       = 1'b1;
      tab_pend_d = 1'b0;
      cur_d      = bwtw_pkg::advance(cfg_q, cur_q);
    end else if (in_acc) begin
      case (s_axis_tdata)
        bwtw_pkg::CodeNewline: begin
          cur_d.col = cfg_q.win_left;
          cur_d.row = bwtw_pkg::next_row(cfg_q, cur_q.row);
        end
        bwtw_pkg::CodeTab: begin
          emit       = 1'b1;
          emit_last  = 1'b0;
          tab_pend_d = 1'b1;
          cur_d      = bwtw_pkg::advance(cfg_q, cur_q);
        end
        bwtw_pkg::CodeBackspace: ;
        default: begin
          emit      = 1'b1;
          emit_code = s_axis_tdata;
          cur_d     = bwtw_pkg::advance(cfg_q, cur_q);
        end
      endcase
    end
  end

  assign prod = (bwtw_pkg::AddrW+1)'(cur_q.row) * (bwtw_pkg::AddrW+1)'(cfg_q.scr_width);
  assign addr = prod[bwtw_pkg::AddrW-1:0] + bwtw_pkg::AddrW'(cur_q.col);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = emit;
      if (emit) begin
        out_data_d = {cfg_q.paper_color, cfg_q.ink_color, emit_code, addr};
        out_last_d = emit_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      tab_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      tab_pend_q  <= tab_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- hdl/bwtw_checker.sv -----
// bwtw_checker: port-level assertions for bounded_window_text_writer_unit, bound to it
// depends on bwtw_pkg

module bwtw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [bwtw_pkg::CharW-1:0]    s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bwtw_pkg::OutDatW-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a tab starts with a non-final space and blocks the next request
  a_tab_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tdata == bwtw_pkg::CodeTab |=> m_axis_tvalid && !m_axis_tlast
      && !s_axis_tready
      && m_axis_tdata[bwtw_pkg::FgLsb-1:bwtw_pkg::GlyphLsb] == bwtw_pkg::CodeSpace)
    else $error("tab first space wrong");

  // printable character gives one final write of its glyph
  a_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tdata != bwtw_pkg::CodeTab && s_axis_tdata != bwtw_pkg::CodeNewline
      && s_axis_tdata != bwtw_pkg::CodeBackspace
    |=> m_axis_tvalid && m_axis_tlast
      && m_axis_tdata[bwtw_pkg::FgLsb-1:bwtw_pkg::GlyphLsb] == $past(s_axis_tdata))
    else $error("printable write wrong");

  // newline and backspace produce nothing
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tdata == bwtw_pkg::CodeNewline
      || s_axis_tdata == bwtw_pkg::CodeBackspace) |=> !m_axis_tvalid)
    else $error("control code produced a write");

endmodule

bind bounded_window_text_writer_unit bwtw_checker u_bwtw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
